[rtl/core/srob_pkg.sv]
package srob_pkg;

	localparam int SEQ_W             = 32;
	localparam int DATA_W            = 32;
	localparam int DEF_WINDOW        = 16;
	localparam int DEF_PAYLOAD_WIDTH = 32;

	localparam logic [1:0] STAT_RELEASED = 2'd0;
	localparam logic [1:0] STAT_HELD     = 2'd1;
	localparam logic [1:0] STAT_STALE    = 2'd2;
	localparam logic [1:0] STAT_BEYOND   = 2'd3;

	typedef struct packed {
		logic beyond;
		logic dup;
		logic inorder;
	} chk_t;

endpackage

[rtl/core/sequence_reorder_buffer.sv]
// The first result of an item is loaded into the output register from the check state once
// that register is free. An in-order item then releases one parked item per cycle from the
// payload memory while the output register is free; the memory's registered read is fetched
// one slot ahead. Input is taken again once the final result of a run is loaded in the output
// register. Reset clears the control state, the slot valid bits and the last released number;
// the payload memory is not cleared, and no clearing pass is needed.
module sequence_reorder_buffer #(
	parameter int WINDOW        = srob_pkg::DEF_WINDOW,
	parameter int PAYLOAD_WIDTH = srob_pkg::DEF_PAYLOAD_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // seq_number [31:0], payload [63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_seq [31:0], out_payload [63:32]
	output logic        m_tlast,
	output logic [2:0]  m_tuser    // emitted [0], status [2:1]
);

	import srob_pkg::*;

	localparam int SW = $clog2(WINDOW);
	localparam logic [SW-1:0] HEAD_LAST = SW'(WINDOW - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]               state_q, state_d;
	logic [SEQ_W-1:0]         last_q;
	logic [SW-1:0]            head_q;
	logic [SW-1:0]            head_inc;
	logic [WINDOW-1:0]        valid_q;
	logic [SEQ_W-1:0]         seq_q;
	logic [DATA_W-1:0]        pay_q;
	logic [SEQ_W-1:0]         diff_q;
	logic                     stale_q;

	logic [SW-1:0]            slot;
	chk_t                     chk;
	logic [SEQ_W-1:0]         rel_seq;
	logic                     cont;
	logic                     out_free;
	logic                     in_xfer;

	logic [63:0]              pay_in_ext;
	logic [PAYLOAD_WIDTH-1:0] pay_st;
	logic [PAYLOAD_WIDTH-1:0] ram_rdata;
	logic [63:0]              rd_ext;
	logic [63:0]              st_ext;
	logic [SW-1:0]            rd_addr;

	logic                     ld_out;
	logic                     adv;
	logic                     wr_en;
	logic                     clr_v;
	logic                     o_emit;
	logic                     o_last;
	logic [1:0]               o_stat;
	logic [SEQ_W-1:0]         o_seq;
	logic [DATA_W-1:0]        o_pay;

	logic                     out_valid_q;
	logic                     out_emit_q;
	logic                     out_last_q;
	logic [1:0]               out_stat_q;
	logic [SEQ_W-1:0]         out_seq_q;
	logic [DATA_W-1:0]        out_pay_q;

	assign s_tready = state_q == S_IDLE;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign head_inc = (head_q == HEAD_LAST) ? '0 : head_q + SW'(1);
	assign rel_seq  = last_q + SEQ_W'(1);
	assign cont     = (rel_seq != '1) && valid_q[head_inc];

	assign pay_in_ext = {32'b0, pay_q};
	assign pay_st     = pay_in_ext[PAYLOAD_WIDTH-1:0];
	assign rd_ext     = 64'(ram_rdata);
	assign st_ext     = 64'(pay_st);

	// Fetch one slot ahead while advancing so the next payload is in the read register when the head moves on.
	assign rd_addr = adv ? head_inc : head_q;

	srob_classify #(
		.WINDOW (WINDOW)
	) u_classify (
		.diff  (diff_q),
		.head  (head_q),
		.valid (valid_q),
		.slot  (slot),
		.chk   (chk)
	);

	srob_ram #(
		.WIDTH (PAYLOAD_WIDTH),
		.DEPTH (WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot),
		.wdata (pay_st),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		ld_out  = 1'b0;
		adv     = 1'b0;
		wr_en   = 1'b0;
		clr_v   = 1'b0;
		o_emit  = 1'b0;
		o_last  = 1'b1;
		o_stat  = STAT_STALE;
		o_seq   = seq_q;
		o_pay   = '0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = S_IDLE;
					if (stale_q) begin
						o_stat = STAT_STALE;
					end else if (chk.beyond) begin
						o_stat = STAT_BEYOND;
					end else if (chk.dup) begin
						o_stat = STAT_STALE;
					end else if (!chk.inorder) begin
						o_stat = STAT_HELD;
						wr_en  = 1'b1;
					end else begin
						// The in-order item goes straight out; its slot is never marked.
						adv     = 1'b1;
						o_emit  = 1'b1;
						o_stat  = STAT_RELEASED;
						o_seq   = rel_seq;
						o_pay   = st_ext[DATA_W-1:0];
						o_last  = !cont;
						state_d = cont ? S_DRAIN : S_IDLE;
					end
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					ld_out  = 1'b1;
					adv     = 1'b1;
					clr_v   = 1'b1;
					o_emit  = 1'b1;
					o_stat  = STAT_RELEASED;
					o_seq   = rel_seq;
					o_pay   = rd_ext[DATA_W-1:0];
					o_last  = !cont;
					state_d = cont ? S_DRAIN : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= '0;
			head_q      <= SW'(1);
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				last_q <= rel_seq;
				head_q <= head_inc;
			end
			if (wr_en) begin
				valid_q[slot] <= 1'b1;
			end
			if (clr_v) begin
				valid_q[head_q] <= 1'b0;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			seq_q   <= s_tdata[31:0];
			pay_q   <= s_tdata[63:32];
			diff_q  <= s_tdata[31:0] - last_q;
			stale_q <= s_tdata[31:0] <= last_q;
		end
		if (ld_out) begin
			out_emit_q <= o_emit;
			out_last_q <= o_last;
			out_stat_q <= o_stat;
			out_seq_q  <= o_seq;
			out_pay_q  <= o_pay;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_pay_q, out_seq_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_stat_q, out_emit_q};

`ifndef SYNTH
	// A run only continues into a slot that holds a parked item.
	a_drain_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> valid_q[head_q])
		else $error("drain at an empty slot");

	// The slot of the next expected number is never parked while waiting for input.
	a_head_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !valid_q[head_q])
		else $error("expected slot parked while idle");

	// No new item is taken while a run is still being released.
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input taken in the middle of a run");

	// Every released result advances the last released number by exactly one.
	a_rel_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_out && o_emit) |=> (last_q == $past(last_q) + SEQ_W'(1)))
		else $error("release did not advance the sequence");
`endif

endmodule

[rtl/core/srob_ram.sv]
module srob_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/srob_classify.sv]
module srob_classify #(
	parameter int WINDOW = 16
) (
	input  logic [srob_pkg::SEQ_W-1:0]  diff,
	input  logic [$clog2(WINDOW)-1:0]   head,
	input  logic [WINDOW-1:0]           valid,
	output logic [$clog2(WINDOW)-1:0]   slot,
	output srob_pkg::chk_t              chk
);

	import srob_pkg::*;

	localparam int SW = $clog2(WINDOW);
	localparam logic [SW:0] WIN_C = (SW+1)'(WINDOW);

	logic [SW:0] offs;
	logic [SW:0] sum;
	logic [SW:0] wrapped;

	// The offset from the expected slot is diff - 1, which lies below WINDOW
	// whenever the item falls inside the window.
	assign offs    = diff[SW:0] - (SW+1)'(1);
	assign sum     = {1'b0, head} + {1'b0, offs[SW-1:0]};
	assign wrapped = (sum >= WIN_C) ? (sum - WIN_C) : sum;
	assign slot    = wrapped[SW-1:0];

	assign chk.beyond  = diff > SEQ_W'(WINDOW);
	assign chk.dup     = valid[slot];
	assign chk.inorder = diff == SEQ_W'(1);

endmodule

[test/sequence_reorder_buffer_tb.sv]
`timescale 1ns / 1ps

module sequence_reorder_buffer_tb;
	import srob_pkg::*;

	localparam int WINDOW        = DEF_WINDOW;
	localparam int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH;
	localparam logic [31:0] PAY_MASK = (PAYLOAD_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << PAYLOAD_WIDTH) - 64'd1);
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic        emitted;
		logic [31:0] seq;
		logic [31:0] pay;
		logic        last;
		logic [1:0]  status;
	} release_rec_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;   // seq_number [31:0], payload [63:32]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;         // out_seq [31:0], out_payload [63:32]
	logic        m_tlast;
	logic [2:0]  m_tuser;         // emitted [0], status [2:1]

	// Shadow copy of the window state, updated at each accepted input transfer.
	logic [31:0] shadow_last_rel = '0;
	logic [31:0] shadow_slot_pay [WINDOW];
	logic        shadow_slot_full [WINDOW];

	release_rec_t expected_results[$];

	int n_fail       = 0;
	int cycle_count  = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_left    = 0;

	sequence_reorder_buffer #(
		.WINDOW        (WINDOW),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < WINDOW; i++) begin
			shadow_slot_full[i] = 1'b0;
			shadow_slot_pay[i]  = '0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, or a counted hold-off when one is requested.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	function automatic void push_result(logic emitted, logic [31:0] seq, logic [31:0] pay,
			logic last, logic [1:0] status);
		release_rec_t r;
		r.emitted = emitted;
		r.seq     = seq;
		r.pay     = pay;
		r.last    = last;
		r.status  = status;
		expected_results.push_back(r);
	endfunction

	function automatic void reorder_predict(logic [31:0] seq, logic [31:0] pay_in);
		logic [31:0] pay;
		logic [31:0] gap;
		logic [31:0] nxt;
		int slot;
		int n;
		pay  = pay_in & PAY_MASK;
		gap  = seq - shadow_last_rel;
		slot = int'(seq % WINDOW);
		if (seq <= shadow_last_rel) begin
			push_result(1'b0, seq, '0, 1'b1, STAT_STALE);
		end else if (gap > WINDOW) begin
			push_result(1'b0, seq, '0, 1'b1, STAT_BEYOND);
		end else if (shadow_slot_full[slot]) begin
			push_result(1'b0, seq, '0, 1'b1, STAT_STALE);
		end else begin
			shadow_slot_full[slot] = 1'b1;
			shadow_slot_pay[slot]  = pay;
			if (seq != shadow_last_rel + 32'd1) begin
				push_result(1'b0, seq, '0, 1'b1, STAT_HELD);
			end else begin
				n = 0;
				while (shadow_last_rel != 32'hFFFF_FFFF && n < WINDOW) begin
					nxt  = shadow_last_rel + 32'd1;
					slot = int'(nxt % WINDOW);
					if (!shadow_slot_full[slot])
						break;
					push_result(1'b1, nxt, shadow_slot_pay[slot], 1'b0, STAT_RELEASED);
					shadow_slot_full[slot] = 1'b0;
					shadow_last_rel = nxt;
					n++;
				end
				expected_results[expected_results.size() - 1].last = 1'b1;
			end
		end
	endfunction

	// Entered and left at a falling edge.
	task automatic send_item(input logic [31:0] seq, input logic [31:0] pay);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pay, seq};
		do
			@(posedge clk);
		while (!s_tready);
		reorder_predict(seq, pay);
		@(negedge clk);
	endtask

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			n_fail++;
		end
	endfunction

	always @(posedge clk) begin
		release_rec_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: out_seq 0x%0h", m_tdata[31:0]);
				n_fail++;
			end else begin
				exp_r = expected_results.pop_front();
				check_field("emitted", 32'(exp_r.emitted), 32'(m_tuser[0]));
				check_field("out_seq", exp_r.seq, m_tdata[31:0]);
				check_field("out_payload", exp_r.pay, m_tdata[63:32]);
				check_field("last_of_run", 32'(exp_r.last), 32'(m_tlast));
				check_field("status", 32'(exp_r.status), 32'(m_tuser[2:1]));
			end
		end
	end

	task automatic test_in_order();
		send_item(shadow_last_rel + 32'd1, 32'h0000_0000);
		send_item(shadow_last_rel + 32'd1, 32'hFFFF_FFFF);
	endtask

	// Exhausting the sequence space is out of reach in a run of practical length.
	task automatic test_drops();
		send_item(32'd0, $urandom);
		send_item(shadow_last_rel, $urandom);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(shadow_last_rel + WINDOW + 1, $urandom);
	endtask

	// A duplicate is dropped and the first payload stays parked.
	task automatic test_duplicate();
		logic [31:0] base;
		logic [31:0] first_pay;
		base      = shadow_last_rel;
		first_pay = $urandom;
		send_item(base + 32'd3, first_pay);
		send_item(base + 32'd3, ~first_pay);
		send_item(base + 32'd2, $urandom);
		send_item(base + 32'd1, $urandom);
	endtask

	// Fill the whole window out of order, then release it in one run.
	task automatic test_full_window();
		logic [31:0] base;
		base = shadow_last_rel;
		for (int i = WINDOW; i >= 2; i--)
			send_item(base + i, $urandom);
		send_item(base + 32'd1, $urandom);
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [31:0] burst[WINDOW];
		logic [31:0] tmp;
		logic [31:0] base;
		int sent;
		int k;
		int j;
		int pick;
		int first;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			base = shadow_last_rel;
			if (pick < 75) begin
				// Shuffled run of the next numbers; sometimes one goes missing.
				k = $urandom_range(WINDOW, 1);
				for (int i = 0; i < k; i++)
					burst[i] = base + i + 1;
				for (int i = k - 1; i > 0; i--) begin
					j        = $urandom_range(i, 0);
					tmp      = burst[i];
					burst[i] = burst[j];
					burst[j] = tmp;
				end
				first = ($urandom_range(99) < 15) ? 1 : 0;
				for (int i = first; i < k; i++) begin
					send_item(burst[i], $urandom);
					sent++;
				end
			end else if (pick < 85) begin
				send_item($urandom_range(base, 0), $urandom);
				sent++;
			end else if (pick < 93) begin
				if ($urandom_range(1, 0) == 1)
					send_item($urandom, $urandom);
				else
					send_item(base + WINDOW + 1 + $urandom_range(3, 0), $urandom);
				sent++;
			end else begin
				send_item(base + $urandom_range(WINDOW, 2), $urandom);
				sent++;
			end
		end
	endtask

	// The receiver stops for a long stretch so the output register stays full and the block refuses input.
	task automatic test_backpressure();
		logic [31:0] base;
		hold_left = 300;
		base = shadow_last_rel;
		for (int i = 4; i >= 1; i--)
			send_item(base + i, $urandom);
		for (int i = 0; i < 36; i++)
			send_item(shadow_last_rel + 32'd1, $urandom);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		snd_idle_pct = 21;
		rcv_idle_pct = 55;
		test_in_order();
		test_drops();
		test_duplicate();
		test_full_window();
		test_random_traffic(135);

		snd_idle_pct = 55;
		rcv_idle_pct = 21;
		test_random_traffic(135);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_backpressure();
		test_random_traffic(135);

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (n_fail == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sequence_reorder_buffer.f]
rtl/core/srob_pkg.sv
rtl/core/srob_ram.sv
rtl/core/srob_classify.sv
rtl/core/sequence_reorder_buffer.sv
test/sequence_reorder_buffer_tb.sv
